@@ hw/rtl/qaar_pkg.sv @@
package qaar_pkg;

   // Width of the CORDIC datapath (Q2.30 plus guard bits).
   localparam int CORDIC_W = 34;
   localparam int CORDIC_STEPS = 24;
   localparam int AXIS_BITS = 16;
   localparam int AXIS_FRAC = 14;
   localparam int Q_FRAC = 30;
   // Quaternion components in Q2.30; a vector part may reach magnitude 2.0.
   localparam int QUAT_W = 34;
   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_ONE = CORDIC_W'(652032874);
   localparam int DEF_COORD_BITS = 32;
   localparam int DEF_ANGLE_BITS = 16;

   // Arctangent of 2^-i, with 2^32 as one full turn.
   function automatic logic signed [CORDIC_W-1:0] atan_of(input int unsigned i);
      logic signed [CORDIC_W-1:0] a;
      case (i)
         0: a = CORDIC_W'(536870912);
         1: a = CORDIC_W'(316933406);
         2: a = CORDIC_W'(167458907);
         3: a = CORDIC_W'(85004756);
         4: a = CORDIC_W'(42667331);
         5: a = CORDIC_W'(21354465);
         6: a = CORDIC_W'(10679838);
         7: a = CORDIC_W'(5340245);
         8: a = CORDIC_W'(2670163);
         9: a = CORDIC_W'(1335087);
         10: a = CORDIC_W'(667544);
         11: a = CORDIC_W'(333772);
         12: a = CORDIC_W'(166886);
         13: a = CORDIC_W'(83443);
         14: a = CORDIC_W'(41722);
         15: a = CORDIC_W'(20861);
         16: a = CORDIC_W'(10430);
         17: a = CORDIC_W'(5215);
         18: a = CORDIC_W'(2608);
         19: a = CORDIC_W'(1304);
         20: a = CORDIC_W'(652);
         21: a = CORDIC_W'(326);
         22: a = CORDIC_W'(163);
         23: a = CORDIC_W'(81);
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

@@ hw/rtl/quaternion_axis_angle_rotate_unit.sv @@
// Channel   | Ports                                  | Handshake
// ----------+----------------------------------------+------------------------------
// request   | req_angle, req_axis_*, req_point_*     | word taken when start && !busy
// response  | rsp_rot_x, rsp_rot_y, rsp_rot_z        | word valid for one cycle on rsp_valid
//
// The unit is a fixed pipeline of 30 register stages: one input stage, one
// stage per CORDIC step (24), one stage forming the quaternion, two stages
// for the first Hamilton product and two for the second one.
// A request word passes through these stages in this order, and a new word may
// enter at every edge, so busy is never asserted.
// The receiver cannot stall, so the pipeline never holds; the valid bits
// travel with the data. Reset clears only the valid bits.
module quaternion_axis_angle_rotate_unit #(
   parameter int COORD_BITS = qaar_pkg::DEF_COORD_BITS,
   parameter int ANGLE_BITS = qaar_pkg::DEF_ANGLE_BITS
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   output logic                                      busy,
   input  logic [ANGLE_BITS-1:0]                     req_angle,
   input  logic signed [qaar_pkg::AXIS_BITS-1:0]     req_axis_x,
   input  logic signed [qaar_pkg::AXIS_BITS-1:0]     req_axis_y,
   input  logic signed [qaar_pkg::AXIS_BITS-1:0]     req_axis_z,
   input  logic signed [COORD_BITS-1:0]              req_point_x,
   input  logic signed [COORD_BITS-1:0]              req_point_y,
   input  logic signed [COORD_BITS-1:0]              req_point_z,
   output logic                                      rsp_valid,
   output logic signed [COORD_BITS-1:0]              rsp_rot_x,
   output logic signed [COORD_BITS-1:0]              rsp_rot_y,
   output logic signed [COORD_BITS-1:0]              rsp_rot_z
);
   import qaar_pkg::*;

   localparam int LATENCY = CORDIC_STEPS + 6;
   // Product and sum widths of the two Hamilton products.
   localparam int TP_W = QUAT_W + COORD_BITS;
   localparam int T_W = TP_W + 2 - Q_FRAC;
   localparam int RP_W = T_W + QUAT_W;
   localparam int RS_W = RP_W + 2;
   localparam int R_W = RS_W - Q_FRAC;
   localparam int H_W = 31;

   localparam logic signed [R_W-1:0] R_MAX = R_W'({1'b0, {(COORD_BITS-1){1'b1}}});
   localparam logic signed [R_W-1:0] R_MIN = -R_MAX - R_W'(1);

   // The pipeline never holds, so a new word is always welcome.
   assign busy = 1'b0;

   logic [LATENCY-1:0] valid_ff;
   logic [LATENCY-1:0] valid_in;

   assign valid_in = {valid_ff[LATENCY-2:0], start};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Input stage: fold the half angle into the first quadrant and seed CORDIC.
   logic [H_W-1:0] h_raw;
   logic           flip_in;
   logic [H_W-1:0] h_fold;

   always_comb begin
      h_raw = H_W'(req_angle) << (H_W - ANGLE_BITS);
      flip_in = h_raw > H_W'(1 << 30);
      h_fold = flip_in ? (H_W'(1 << 30) - h_raw) + H_W'(1 << 30) : h_raw;
   end

   logic signed [CORDIC_W-1:0] x_ff [0:CORDIC_STEPS];
   logic signed [CORDIC_W-1:0] y_ff [0:CORDIC_STEPS];
   logic signed [CORDIC_W-1:0] z_ff [0:CORDIC_STEPS];
   logic                       flip_ff [0:CORDIC_STEPS];
   logic signed [AXIS_BITS-1:0] ax_ff [0:CORDIC_STEPS];
   logic signed [AXIS_BITS-1:0] ay_ff [0:CORDIC_STEPS];
   logic signed [AXIS_BITS-1:0] az_ff [0:CORDIC_STEPS];
   logic signed [COORD_BITS-1:0] px_ff [0:CORDIC_STEPS+1];
   logic signed [COORD_BITS-1:0] py_ff [0:CORDIC_STEPS+1];
   logic signed [COORD_BITS-1:0] pz_ff [0:CORDIC_STEPS+1];

   always_ff @(posedge clock) begin
      x_ff[0] <= CORDIC_GAIN_ONE;
      y_ff[0] <= '0;
      z_ff[0] <= CORDIC_W'(h_fold);
      flip_ff[0] <= flip_in;
      ax_ff[0] <= req_axis_x;
      ay_ff[0] <= req_axis_y;
      az_ff[0] <= req_axis_z;
      px_ff[0] <= req_point_x;
      py_ff[0] <= req_point_y;
      pz_ff[0] <= req_point_z;
   end

   // One CORDIC rotation per stage; both updates use the previous x and y.
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      logic signed [CORDIC_W-1:0] x_in;
      logic signed [CORDIC_W-1:0] y_in;
      logic signed [CORDIC_W-1:0] z_in;
      logic signed [CORDIC_W-1:0] dx;
      logic signed [CORDIC_W-1:0] dy;

      always_comb begin
         dx = x_ff[i] >>> i;
         dy = y_ff[i] >>> i;
         if (!z_ff[i][CORDIC_W-1]) begin
            x_in = x_ff[i] - dy;
            y_in = y_ff[i] + dx;
            z_in = z_ff[i] - atan_of(i);
         end else begin
            x_in = x_ff[i] + dy;
            y_in = y_ff[i] - dx;
            z_in = z_ff[i] + atan_of(i);
         end
      end

      always_ff @(posedge clock) begin
         x_ff[i+1] <= x_in;
         y_ff[i+1] <= y_in;
         z_ff[i+1] <= z_in;
         flip_ff[i+1] <= flip_ff[i];
         ax_ff[i+1] <= ax_ff[i];
         ay_ff[i+1] <= ay_ff[i];
         az_ff[i+1] <= az_ff[i];
         px_ff[i+1] <= px_ff[i];
         py_ff[i+1] <= py_ff[i];
         pz_ff[i+1] <= pz_ff[i];
      end
   end

   // Quaternion stage: vector part is axis times sine, rounded back to Q2.30.
   localparam int AS_W = AXIS_BITS + CORDIC_W;
   logic signed [AS_W-1:0] sx, sy, sz;
   logic signed [QUAT_W-1:0] qx_in, qy_in, qz_in, qw_in;
   logic signed [QUAT_W-1:0] qx_ff [0:2];
   logic signed [QUAT_W-1:0] qy_ff [0:2];
   logic signed [QUAT_W-1:0] qz_ff [0:2];
   logic signed [QUAT_W-1:0] qw_ff [0:2];

   always_comb begin
      sx = AS_W'(ax_ff[CORDIC_STEPS]) * AS_W'(y_ff[CORDIC_STEPS]) + AS_W'(1 << 13);
      sy = AS_W'(ay_ff[CORDIC_STEPS]) * AS_W'(y_ff[CORDIC_STEPS]) + AS_W'(1 << 13);
      sz = AS_W'(az_ff[CORDIC_STEPS]) * AS_W'(y_ff[CORDIC_STEPS]) + AS_W'(1 << 13);
      qx_in = QUAT_W'(sx >>> AXIS_FRAC);
      qy_in = QUAT_W'(sy >>> AXIS_FRAC);
      qz_in = QUAT_W'(sz >>> AXIS_FRAC);
      qw_in = flip_ff[CORDIC_STEPS] ? -QUAT_W'(x_ff[CORDIC_STEPS])
                                    : QUAT_W'(x_ff[CORDIC_STEPS]);
   end

   always_ff @(posedge clock) begin
      qx_ff[0] <= qx_in;
      qy_ff[0] <= qy_in;
      qz_ff[0] <= qz_in;
      qw_ff[0] <= qw_in;
      px_ff[CORDIC_STEPS+1] <= px_ff[CORDIC_STEPS];
      py_ff[CORDIC_STEPS+1] <= py_ff[CORDIC_STEPS];
      pz_ff[CORDIC_STEPS+1] <= pz_ff[CORDIC_STEPS];
      for (int k = 1; k < 3; k++) begin
         qx_ff[k] <= qx_ff[k-1];
         qy_ff[k] <= qy_ff[k-1];
         qz_ff[k] <= qz_ff[k-1];
         qw_ff[k] <= qw_ff[k-1];
      end
   end

   // First Hamilton product t = q * p: twelve products, then sums.
   logic signed [TP_W-1:0] tp_ff [0:11];
   logic signed [TP_W-1:0] tp_in [0:11];

   always_comb begin
      tp_in[0]  = TP_W'(qx_ff[0]) * TP_W'(px_ff[CORDIC_STEPS+1]);
      tp_in[1]  = TP_W'(qy_ff[0]) * TP_W'(py_ff[CORDIC_STEPS+1]);
      tp_in[2]  = TP_W'(qz_ff[0]) * TP_W'(pz_ff[CORDIC_STEPS+1]);
      tp_in[3]  = TP_W'(qw_ff[0]) * TP_W'(px_ff[CORDIC_STEPS+1]);
      tp_in[4]  = TP_W'(qy_ff[0]) * TP_W'(pz_ff[CORDIC_STEPS+1]);
      tp_in[5]  = TP_W'(qz_ff[0]) * TP_W'(py_ff[CORDIC_STEPS+1]);
      tp_in[6]  = TP_W'(qw_ff[0]) * TP_W'(py_ff[CORDIC_STEPS+1]);
      tp_in[7]  = TP_W'(qz_ff[0]) * TP_W'(px_ff[CORDIC_STEPS+1]);
      tp_in[8]  = TP_W'(qx_ff[0]) * TP_W'(pz_ff[CORDIC_STEPS+1]);
      tp_in[9]  = TP_W'(qw_ff[0]) * TP_W'(pz_ff[CORDIC_STEPS+1]);
      tp_in[10] = TP_W'(qx_ff[0]) * TP_W'(py_ff[CORDIC_STEPS+1]);
      tp_in[11] = TP_W'(qy_ff[0]) * TP_W'(px_ff[CORDIC_STEPS+1]);
   end

   always_ff @(posedge clock) begin
      tp_ff <= tp_in;
   end

   localparam int TS_W = TP_W + 2;
   localparam logic signed [TS_W-1:0] T_HALF = TS_W'(1 << 29);
   logic signed [TS_W-1:0] tws, txs, tys, tzs;
   logic signed [T_W-1:0] tw_ff, tx_ff, ty_ff, tz_ff;

   always_comb begin
      tws = T_HALF - TS_W'(tp_ff[0]) - TS_W'(tp_ff[1]) - TS_W'(tp_ff[2]);
      txs = T_HALF + TS_W'(tp_ff[3]) + TS_W'(tp_ff[4]) - TS_W'(tp_ff[5]);
      tys = T_HALF + TS_W'(tp_ff[6]) + TS_W'(tp_ff[7]) - TS_W'(tp_ff[8]);
      tzs = T_HALF + TS_W'(tp_ff[9]) + TS_W'(tp_ff[10]) - TS_W'(tp_ff[11]);
   end

   always_ff @(posedge clock) begin
      tw_ff <= T_W'(tws >>> Q_FRAC);
      tx_ff <= T_W'(txs >>> Q_FRAC);
      ty_ff <= T_W'(tys >>> Q_FRAC);
      tz_ff <= T_W'(tzs >>> Q_FRAC);
   end

   // Second Hamilton product r = t * conj(q), vector part only.
   logic signed [RP_W-1:0] rp_ff [0:11];
   logic signed [RP_W-1:0] rp_in [0:11];

   always_comb begin
      rp_in[0]  = RP_W'(tx_ff) * RP_W'(qw_ff[2]);
      rp_in[1]  = RP_W'(tw_ff) * RP_W'(qx_ff[2]);
      rp_in[2]  = RP_W'(ty_ff) * RP_W'(qz_ff[2]);
      rp_in[3]  = RP_W'(tz_ff) * RP_W'(qy_ff[2]);
      rp_in[4]  = RP_W'(ty_ff) * RP_W'(qw_ff[2]);
      rp_in[5]  = RP_W'(tw_ff) * RP_W'(qy_ff[2]);
      rp_in[6]  = RP_W'(tz_ff) * RP_W'(qx_ff[2]);
      rp_in[7]  = RP_W'(tx_ff) * RP_W'(qz_ff[2]);
      rp_in[8]  = RP_W'(tz_ff) * RP_W'(qw_ff[2]);
      rp_in[9]  = RP_W'(tw_ff) * RP_W'(qz_ff[2]);
      rp_in[10] = RP_W'(tx_ff) * RP_W'(qy_ff[2]);
      rp_in[11] = RP_W'(ty_ff) * RP_W'(qx_ff[2]);
   end

   always_ff @(posedge clock) begin
      rp_ff <= rp_in;
   end

   localparam logic signed [RS_W-1:0] R_HALF = RS_W'(1 << 29);
   logic signed [RS_W-1:0] rxs, rys, rzs;
   logic signed [R_W-1:0] rx, ry, rz;
   logic signed [COORD_BITS-1:0] rot_x_in, rot_y_in, rot_z_in;
   logic signed [COORD_BITS-1:0] rot_x_ff, rot_y_ff, rot_z_ff;

   function automatic logic signed [COORD_BITS-1:0] clamp(input logic signed [R_W-1:0] v);
      logic signed [COORD_BITS-1:0] c;
      if (v > R_MAX) begin
         c = COORD_BITS'(R_MAX);
      end else if (v < R_MIN) begin
         c = COORD_BITS'(R_MIN);
      end else begin
         c = COORD_BITS'(v);
      end
      return c;
   endfunction

   always_comb begin
      rxs = R_HALF + RS_W'(rp_ff[0]) - RS_W'(rp_ff[1]) - RS_W'(rp_ff[2])
            + RS_W'(rp_ff[3]);
      rys = R_HALF + RS_W'(rp_ff[4]) - RS_W'(rp_ff[5]) - RS_W'(rp_ff[6])
            + RS_W'(rp_ff[7]);
      rzs = R_HALF + RS_W'(rp_ff[8]) - RS_W'(rp_ff[9]) - RS_W'(rp_ff[10])
            + RS_W'(rp_ff[11]);
      rx = R_W'(rxs >>> Q_FRAC);
      ry = R_W'(rys >>> Q_FRAC);
      rz = R_W'(rzs >>> Q_FRAC);
      rot_x_in = clamp(rx);
      rot_y_in = clamp(ry);
      rot_z_in = clamp(rz);
   end

   always_ff @(posedge clock) begin
      rot_x_ff <= rot_x_in;
      rot_y_ff <= rot_y_in;
      rot_z_ff <= rot_z_in;
   end

   assign rsp_valid = valid_ff[LATENCY-1];
   assign rsp_rot_x = rot_x_ff;
   assign rsp_rot_y = rot_y_ff;
   assign rsp_rot_z = rot_z_ff;

   // Every accepted word comes out at the end of the pipeline as a response word.
   a_latency_out : assert property (@(posedge clock) disable iff (reset)
      start |-> ##LATENCY rsp_valid)
      else $error("accepted word did not emerge after the pipeline latency");

   // No response word appears without a request word that caused it.
   a_no_invent : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LATENCY))
      else $error("response word without a matching request word");

   // The CORDIC seed is always a first-quadrant half angle.
   a_cordic_range : assert property (@(posedge clock) disable iff (reset)
      valid_ff[0] |-> (z_ff[0] <= CORDIC_W'(1 << 30)))
      else $error("folded half angle out of range");

endmodule

@@ verif/qaar_rotate_checker.sv @@
`timescale 1ns / 100ps

// Watches the request and response channels of the rotate unit, predicts the
// rotated point for every accepted request word and compares response words
// in order against those predictions.
module qaar_rotate_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [15:0]        req_angle,
   input  logic signed [15:0] req_axis_x,
   input  logic signed [15:0] req_axis_y,
   input  logic signed [15:0] req_axis_z,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic signed [31:0] req_point_z,
   input  logic               rsp_valid,
   input  logic signed [31:0] rsp_rot_x,
   input  logic signed [31:0] rsp_rot_y,
   input  logic signed [31:0] rsp_rot_z,
   output int                 error_count,
   output int                 pending_count
);
   import qaar_pkg::*;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } point_type;

   point_type rotated_q[$];

   // Half-angle sine and cosine in Q2.30 by 24 CORDIC rotations.
   task automatic half_sin_cos(input logic [15:0] ang, output longint s, output longint c);
      longint h, x, y, z, dx, dy;
      bit flip;
      h = longint'({ang, 16'h0}) >>> 1;
      flip = 0;
      if (h > (64'sd1 <<< 30)) begin
         h = (64'sd1 <<< 31) - h;
         flip = 1;
      end
      x = 64'sd652032874;
      y = 64'sd0;
      z = h;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = x >>> i;
         dy = y >>> i;
         if (z >= 0) begin
            x = x - dy; y = y + dx; z = z - longint'(atan_of(i));
         end else begin
            x = x + dy; y = y - dx; z = z + longint'(atan_of(i));
         end
      end
      s = y;
      c = flip ? -x : x;
   endtask

   // Four-term dot product rounded from Q.30 scaling, half up.
   function automatic longint dot4(input longint a0, b0, a1, b1, a2, b2, a3, b3);
      logic signed [127:0] acc;
      acc = 128'(a0) * 128'(b0) + 128'(a1) * 128'(b1)
          + 128'(a2) * 128'(b2) + 128'(a3) * 128'(b3) + (128'sd1 <<< 29);
      acc = acc >>> 30;
      return acc[63:0];
   endfunction

   function automatic logic signed [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic longint axis_scale(input logic signed [15:0] a, input longint s);
      return (longint'(a) * s + (64'sd1 <<< 13)) >>> 14;
   endfunction

   task automatic predict_rotation(output point_type r);
      longint s, c, qx, qy, qz, qw, px, py, pz, tw, tx, ty, tz;
      half_sin_cos(req_angle, s, c);
      qx = axis_scale(req_axis_x, s);
      qy = axis_scale(req_axis_y, s);
      qz = axis_scale(req_axis_z, s);
      qw = c;
      px = longint'(req_point_x);
      py = longint'(req_point_y);
      pz = longint'(req_point_z);
      tw = dot4(-qx, px, -qy, py, -qz, pz, 0, 0);
      tx = dot4(qw, px, qy, pz, -qz, py, 0, 0);
      ty = dot4(qw, py, qz, px, -qx, pz, 0, 0);
      tz = dot4(qw, pz, qx, py, -qy, px, 0, 0);
      r.x = clamp32(dot4(tx, qw, tw, -qx, ty, -qz, tz, qy));
      r.y = clamp32(dot4(ty, qw, tw, -qy, tz, -qx, tx, qz));
      r.z = clamp32(dot4(tz, qw, tw, -qz, tx, -qy, ty, qx));
   endtask

   assign pending_count = rotated_q.size();

   always @(posedge clock) begin
      point_type exp_pt;
      if (reset) begin
         error_count <= 0;
      end else begin
         if (start && !busy) begin
            predict_rotation(exp_pt);
            rotated_q.push_back(exp_pt);
         end
         if (rsp_valid) begin
            if (rotated_q.size() == 0) begin
               $display("%0t: response word with none expected: %h %h %h",
                        $time, rsp_rot_x, rsp_rot_y, rsp_rot_z);
               error_count <= error_count + 1;
            end else begin
               exp_pt = rotated_q.pop_front();
               if (exp_pt.x !== rsp_rot_x || exp_pt.y !== rsp_rot_y
                   || exp_pt.z !== rsp_rot_z) begin
                  $display("%0t: rotated point expected %0d %0d %0d, actual %0d %0d %0d",
                           $time, exp_pt.x, exp_pt.y, exp_pt.z,
                           rsp_rot_x, rsp_rot_y, rsp_rot_z);
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end
endmodule

@@ verif/quaternion_axis_angle_rotate_unit_tb.sv @@
`timescale 1ns / 100ps

// Top of the rotate unit bench. It drives request words (a directed set, then
// random ones at three idle rates) and leaves all checking to the checker.
module quaternion_axis_angle_rotate_unit_tb;
   logic               clock = 0;
   logic               reset = 1;
   logic               start = 0;
   logic               busy;
   logic [15:0]        req_angle = '0;
   logic signed [15:0] req_axis_x = '0, req_axis_y = '0, req_axis_z = '0;
   logic signed [31:0] req_point_x = '0, req_point_y = '0, req_point_z = '0;
   logic               rsp_valid;
   logic signed [31:0] rsp_rot_x, rsp_rot_y, rsp_rot_z;
   int                 error_count, pending_count;
   int                 cycle_count = 0;

   // The pipeline is 30 stages deep; the drain wait covers it with margin.
   localparam int PIPE_DEPTH = 30;
   localparam int CYCLE_LIMIT = 200000;

   always #5 clock = ~clock;

   quaternion_axis_angle_rotate_unit u_top (.*);

   qaar_rotate_checker u_checker (.*);

   // Watchdog: far beyond the slowest correct run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("quaternion_axis_angle_rotate_unit verification failed");
         $finish;
      end
   end

   // Random axis component: +1.0 or -1.0, a value between -1.0 and 1.0, or
   // sometimes any 16-bit value, so every bit of the field toggles.
   function automatic logic signed [15:0] rand_axis();
      case ($urandom_range(0, 3))
         0: return 16'($urandom);
         1: return 16'sd16384;
         2: return -16'sd16384;
         default: return 16'($signed($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   // Points are mostly moderate so rotations do not saturate, with full-range
   // values mixed in to reach the clamp.
   function automatic logic signed [31:0] rand_coord();
      if ($urandom_range(0, 3) == 0) return 32'($urandom);
      return 32'($signed($urandom_range(0, 32'h01ff_ffff)) - 32'sh0100_0000);
   endfunction

   // Present one word and hold it until it is taken. start stays high between
   // back-to-back words; it is dropped only when the sender idles.
   task automatic send_word(input logic [15:0] ang, input logic signed [15:0] ax, ay, az,
                            input logic signed [31:0] px, py, pz, input int idle_pct);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_angle <= ang;
      req_axis_x <= ax; req_axis_y <= ay; req_axis_z <= az;
      req_point_x <= px; req_point_y <= py; req_point_z <= pz;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic send_random(input int count, input int idle_pct);
      for (int i = 0; i < count; i++)
         send_word(16'($urandom), rand_axis(), rand_axis(), rand_axis(),
                   rand_coord(), rand_coord(), rand_coord(), idle_pct);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;
   localparam logic signed [31:0] MAX_C = 32'sh7fff_ffff;
   localparam logic signed [31:0] MIN_C = 32'sh8000_0000;
   localparam logic signed [15:0] UNIT = 16'sd16384;
   localparam logic signed [15:0] AX_MIN = 16'sh8000;

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words: zero and quarter turns, the half-angle fold point just
      // past a half turn, the largest angle, an axis of zero, a non-unit axis,
      // the -2.0 axis code and points at the coordinate extremes.
      send_word(16'h0000, UNIT, 0, 0, ONE_Q16, ONE_Q16, ONE_Q16, 0);
      send_word(16'h4000, 0, 0, UNIT, ONE_Q16, 0, 0, 0);
      send_word(16'h4000, UNIT, 0, 0, 0, ONE_Q16, 0, 0);
      send_word(16'h4000, 0, UNIT, 0, 0, 0, ONE_Q16, 0);
      send_word(16'h8000, 0, 0, UNIT, ONE_Q16, 2 * ONE_Q16, 0, 0);
      send_word(16'h8001, 0, 0, UNIT, ONE_Q16, 2 * ONE_Q16, 0, 0);
      send_word(16'hc000, 0, 0, -UNIT, ONE_Q16, 0, -ONE_Q16, 0);
      send_word(16'hffff, UNIT, 0, 0, 0, ONE_Q16, 0, 0);
      send_word(16'h2000, 0, 0, 0, MAX_C, MIN_C, ONE_Q16, 0);
      send_word(16'h2000, 16'sd11585, 16'sd11585, 0, ONE_Q16, 0, 0, 0);
      send_word(16'h4000, 16'sh7fff, 16'sh7fff, 16'sh7fff, MAX_C, MAX_C, MAX_C, 0);
      send_word(16'h6000, AX_MIN, 0, 0, MIN_C, MIN_C, MIN_C, 0);
      send_word(16'h1234, AX_MIN, AX_MIN, AX_MIN, MAX_C, MIN_C, MAX_C, 0);
      send_word(16'h0000, 0, 0, 0, MIN_C, MAX_C, -1, 0);
      send_word(16'h8000, UNIT, 0, 0, MAX_C, MAX_C, MIN_C, 0);
      send_word(16'h4000, -UNIT, 0, 0, 0, MIN_C, MAX_C, 0);

      // Sender pauses here until every outstanding rotation has come back.
      wait_drained();

      send_random(220, 27);
      send_random(210, 48);
      send_random(210, 0);

      wait_drained();
      repeat (PIPE_DEPTH + 10) @(posedge clock);
      if (error_count == 0)
         $display("quaternion_axis_angle_rotate_unit verification clean");
      else
         $display("quaternion_axis_angle_rotate_unit verification failed");
      $finish;
   end
endmodule
